>>> rtl/core/prim_minimum_spanning_tree_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the spanning tree RTL
// Each use expands to one labeled concurrent assertion on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH

// same-cycle implication
`define PMST_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// Types and constants shared by the spanning tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package pmst_pkg;

  localparam int OP_W    = 2;
  localparam int VTX_W   = 4;
  localparam int WGT_W   = 16;
  localparam int VC_W    = 5;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  typedef logic [OP_W-1:0]  op_t;
  typedef logic [VTX_W-1:0] vtx_t;
  typedef logic [WGT_W-1:0] wgt_t;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_RUN   = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  localparam wgt_t NO_EDGE = 16'hFFFF;

  // register index = paddr[2]
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [VC_W-1:0] VC_RESET = 5'd8;

  typedef struct packed {
    vtx_t tree_vertex;
    vtx_t parent_vertex;
    wgt_t edge_weight;
    logic last;
    logic disconnected;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/pmst_if.sv
// ----------------------------------------------------------------------------
// pmst_if
// Valid/ready channels for command words in and tree-edge words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmst_in_if import pmst_pkg::*; ();
  logic valid;
  logic ready;
  op_t  operation;
  vtx_t row_vertex;
  vtx_t col_vertex;
  wgt_t weight;

  modport source (output valid, operation, row_vertex, col_vertex, weight, input ready);
  modport sink   (input valid, operation, row_vertex, col_vertex, weight, output ready);
endinterface

interface pmst_out_if import pmst_pkg::*; ();
  logic valid;
  logic ready;
  vtx_t tree_vertex;
  vtx_t parent_vertex;
  wgt_t edge_weight;
  logic last;
  logic disconnected;

  modport source (output valid, tree_vertex, parent_vertex, edge_weight, last, disconnected,
                  input ready);
  modport sink   (input valid, tree_vertex, parent_vertex, edge_weight, last, disconnected,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/pmst_ram.sv
// ----------------------------------------------------------------------------
// pmst_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/pmst_cfg.sv
// ----------------------------------------------------------------------------
// pmst_cfg
// APB register file: holds vertex_count.
// ----------------------------------------------------------------------------
`default_nettype none

module pmst_cfg import pmst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [VC_W-1:0]   vertex_count
);

  logic [VC_W-1:0] vc_r;
  logic [VC_W-1:0] vc_nxt;
  logic            wr_en;

  assign wr_en = psel && penable && pwrite;

  always_comb begin
    vc_nxt = vc_r;
    if (wr_en && (paddr[CFG_AW-1:2] == REG_VERTEX_COUNT)) begin
      vc_nxt = pwdata[VC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else begin
      vc_r <= vc_nxt;
    end
  end

  assign prdata       = (paddr[CFG_AW-1:2] == REG_VERTEX_COUNT) ? CFG_DW'(vc_r) : '0;
  assign pready       = 1'b1;
  assign vertex_count = vc_r;

endmodule

`default_nettype wire

>>> rtl/core/pmst_engine.sv
// ----------------------------------------------------------------------------
// pmst_engine
// Command sequencer and Prim datapath around the weight and nearest-vertex RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "prim_minimum_spanning_tree_assert.svh"

module pmst_engine import pmst_pkg::*; #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  pmst_in_if.sink              in_ch,
  input  wire logic [VC_W-1:0] vertex_count,
  output logic                 res_valid,
  output res_t                 res,
  input  wire logic            res_take
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int AW     = 2 * VW;
  localparam int WDEPTH = 1 << AW;
  localparam int EW     = (VW > VTX_W) ? VW : VTX_W;
  localparam int CW     = (NW > VC_W) ? NW : VC_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WR1      = 4'd1;
  localparam logic [3:0] S_WR2      = 4'd2;
  localparam logic [3:0] S_CLR      = 4'd3;
  localparam logic [3:0] S_SEED     = 4'd4;
  localparam logic [3:0] S_SEED_W   = 4'd5;
  localparam logic [3:0] S_SEED_DEC = 4'd6;
  localparam logic [3:0] S_SWEEP    = 4'd7;
  localparam logic [3:0] S_DR1      = 4'd8;
  localparam logic [3:0] S_DR2      = 4'd9;
  localparam logic [3:0] S_SW_DEC   = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;

  // control
  logic [3:0]              state_r, state_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [MAX_VERTICES-1:0] in_tree_r, in_tree_nxt;
  logic                    s_v_r, p1_v_r, p2_v_r;

  // payload
  logic [VW-1:0]    wr_row_r, wr_row_nxt, wr_col_r, wr_col_nxt;
  wgt_t             wr_wgt_r, wr_wgt_nxt;
  logic [NW-1:0]    n_r, n_nxt, added_r, added_nxt;
  logic [VW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [VW-1:0]    s_i_r, s_j_r;
  wgt_t             best_r, best_nxt;
  logic [VW-1:0]    bv_r, bv_nxt, bp_r, bp_nxt;
  logic [VW-1:0]    pick_r, pick_nxt, root_r, root_nxt;
  logic             seed_r, seed_nxt;
  logic [VW-1:0]    p1_k_r, p2_k_r, p2_nv_r;
  res_t             res_r, res_nxt;
  logic             end_r, end_nxt;

  // memory ports
  logic          w_we;
  logic [AW-1:0] w_waddr, w_raddr_a, w_raddr_b;
  wgt_t          w_wdata, w_rdata_a, w_rdata_b;
  logic          nb_we;
  logic [VW-1:0] nb_waddr, nb_wdata, nb_raddr, nb_rdata;

  // helpers
  logic [EW-1:0] row_e, col_e, bv_e, bp_e;
  logic          row_ok, col_ok;
  logic [CW-1:0] vc_e;
  logic [NW-1:0] n_clamp;
  logic [VW-1:0] n_m1, n_m2, nv1, newnv;
  logic          take_pick;
  wgt_t          key;

  // two copies of the matrix give two reads per cycle
  pmst_ram #(.WIDTH(WGT_W), .DEPTH(WDEPTH)) u_wgt_a (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr_a), .rdata(w_rdata_a)
  );

  pmst_ram #(.WIDTH(WGT_W), .DEPTH(WDEPTH)) u_wgt_b (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr_b), .rdata(w_rdata_b)
  );

  pmst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_near (
    .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
    .raddr(nb_raddr), .rdata(nb_rdata)
  );

  assign row_e  = EW'(in_ch.row_vertex);
  assign col_e  = EW'(in_ch.col_vertex);
  assign row_ok = 32'(in_ch.row_vertex) < 32'(MAX_VERTICES);
  assign col_ok = 32'(in_ch.col_vertex) < 32'(MAX_VERTICES);
  assign bv_e   = EW'(bv_r);
  assign bp_e   = EW'(bp_r);

  assign vc_e = CW'(vertex_count);
  always_comb begin
    priority if (vc_e < CW'(2)) begin
      n_clamp = NW'(2);
    end else if (vc_e > CW'(MAX_VERTICES)) begin
      n_clamp = NW'(MAX_VERTICES);
    end else begin
      n_clamp = vc_e[NW-1:0];
    end
  end

  assign n_m1 = VW'(n_r - NW'(1));
  assign n_m2 = VW'(n_r - NW'(2));

  // matrix write port: edge writes and clearing pass
  always_comb begin
    w_we    = 1'b0;
    w_waddr = clr_cnt_r;
    w_wdata = NO_EDGE;
    priority if (state_r == S_WR1) begin
      w_we    = 1'b1;
      w_waddr = {wr_row_r, wr_col_r};
      w_wdata = wr_wgt_r;
    end else if (state_r == S_WR2) begin
      w_we    = 1'b1;
      w_waddr = {wr_col_r, wr_row_r};
      w_wdata = wr_wgt_r;
    end else if (state_r == S_CLR) begin
      w_we = 1'b1;
    end
  end

  // sweep stage 1: nearest vertex known, fetch both weights
  assign nv1       = seed_r ? root_r : nb_rdata;
  assign w_raddr_a = (state_r == S_SEED) ? {i_r, j_r} : {pick_r, p1_k_r};
  assign w_raddr_b = {nv1, p1_k_r};
  assign nb_raddr  = k_r;

  // sweep stage 2: new pick strictly nearer replaces the old nearest vertex
  assign take_pick = w_rdata_a < w_rdata_b;
  assign newnv     = take_pick ? pick_r : p2_nv_r;
  assign key       = take_pick ? w_rdata_a : w_rdata_b;
  assign nb_we     = p2_v_r;
  assign nb_waddr  = p2_k_r;
  assign nb_wdata  = newnv;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_tree_nxt = in_tree_r;
    wr_row_nxt  = wr_row_r;
    wr_col_nxt  = wr_col_r;
    wr_wgt_nxt  = wr_wgt_r;
    n_nxt       = n_r;
    added_nxt   = added_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    best_nxt    = best_r;
    bv_nxt      = bv_r;
    bp_nxt      = bp_r;
    pick_nxt    = pick_r;
    root_nxt    = root_r;
    seed_nxt    = seed_r;
    res_nxt     = res_r;
    end_nxt     = end_r;

    // seed scan: first strictly smaller upper-triangle weight
    if (s_v_r && (w_rdata_a < best_r)) begin
      best_nxt = w_rdata_a;
      bv_nxt   = s_j_r;
      bp_nxt   = s_i_r;
    end

    // sweep: cheapest vertex outside the tree
    if (p2_v_r && !in_tree_r[p2_k_r] && (key < best_r)) begin
      best_nxt = key;
      bv_nxt   = p2_k_r;
      bp_nxt   = newnv;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.operation)
            OP_WRITE: begin
              wr_row_nxt = row_e[VW-1:0];
              wr_col_nxt = col_e[VW-1:0];
              wr_wgt_nxt = in_ch.weight;
              if (row_ok && col_ok) begin
                state_nxt = S_WR1;
              end
            end
            OP_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
            OP_RUN: begin
              n_nxt       = n_clamp;
              i_nxt       = '0;
              j_nxt       = VW'(1);
              best_nxt    = NO_EDGE;
              in_tree_nxt = '0;
              state_nxt   = S_SEED;
            end
            OP_NONE: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WR1: begin
        state_nxt = S_WR2;
      end
      S_WR2: begin
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_SEED: begin
        priority if ((i_r == n_m2) && (j_r == n_m1)) begin
          state_nxt = S_SEED_W;
        end else if (j_r == n_m1) begin
          i_nxt = i_r + VW'(1);
          j_nxt = i_r + VW'(2);
        end else begin
          j_nxt = j_r + VW'(1);
        end
      end
      S_SEED_W: begin
        state_nxt = S_SEED_DEC;
      end
      S_SEED_DEC: begin
        if (best_r == NO_EDGE) begin
          res_nxt = '{tree_vertex: '0, parent_vertex: '0, edge_weight: NO_EDGE,
                      last: 1'b1, disconnected: 1'b1};
          end_nxt = 1'b1;
        end else begin
          in_tree_nxt[bv_r] = 1'b1;
          in_tree_nxt[bp_r] = 1'b1;
          pick_nxt  = bv_r;
          root_nxt  = bp_r;
          seed_nxt  = 1'b1;
          added_nxt = NW'(2);
          res_nxt   = '{tree_vertex: bv_e[VTX_W-1:0], parent_vertex: bp_e[VTX_W-1:0],
                        edge_weight: best_r, last: (n_r == NW'(2)), disconnected: 1'b0};
          end_nxt   = (n_r == NW'(2));
        end
        state_nxt = S_EMIT;
      end
      S_SWEEP: begin
        k_nxt = k_r + VW'(1);
        if (k_r == n_m1) begin
          state_nxt = S_DR1;
        end
      end
      S_DR1: begin
        state_nxt = S_DR2;
      end
      S_DR2: begin
        state_nxt = S_SW_DEC;
      end
      S_SW_DEC: begin
        if (best_r == NO_EDGE) begin
          res_nxt = '{tree_vertex: '0, parent_vertex: '0, edge_weight: NO_EDGE,
                      last: 1'b1, disconnected: 1'b1};
          end_nxt = 1'b1;
        end else begin
          in_tree_nxt[bv_r] = 1'b1;
          pick_nxt  = bv_r;
          seed_nxt  = 1'b0;
          added_nxt = added_r + NW'(1);
          res_nxt   = '{tree_vertex: bv_e[VTX_W-1:0], parent_vertex: bp_e[VTX_W-1:0],
                        edge_weight: best_r, last: (NW'(added_r + NW'(1)) == n_r),
                        disconnected: 1'b0};
          end_nxt   = (NW'(added_r + NW'(1)) == n_r);
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_take) begin
          if (end_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = '0;
            best_nxt  = NO_EDGE;
            state_nxt = S_SWEEP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      in_tree_r <= '0;
      s_v_r     <= 1'b0;
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      in_tree_r <= in_tree_nxt;
      s_v_r     <= (state_r == S_SEED);
      p1_v_r    <= (state_r == S_SWEEP);
      p2_v_r    <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    wr_row_r <= wr_row_nxt;
    wr_col_r <= wr_col_nxt;
    wr_wgt_r <= wr_wgt_nxt;
    n_r      <= n_nxt;
    added_r  <= added_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    s_i_r    <= i_r;
    s_j_r    <= j_r;
    best_r   <= best_nxt;
    bv_r     <= bv_nxt;
    bp_r     <= bp_nxt;
    pick_r   <= pick_nxt;
    root_r   <= root_nxt;
    seed_r   <= seed_nxt;
    p1_k_r   <= k_r;
    p2_k_r   <= p1_k_r;
    p2_nv_r  <= nv1;
    res_r    <= res_nxt;
    end_r    <= end_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_EMIT);
  assign res         = res_r;

  `PMST_ASSERT_IMPLY(a_disc_is_last, res_valid && res.disconnected, res.last,
                     "disconnected word not flagged last")
  `PMST_ASSERT_NEXT(a_end_to_idle, (state_r == S_EMIT) && res_take && end_r,
                    state_r == S_IDLE, "run did not finish after its last word")
  `PMST_ASSERT_IMPLY(a_no_write_in_scan, s_v_r || p2_v_r, !w_we,
                     "weight matrix written while a scan is in flight")
  `PMST_ASSERT_IMPLY(a_tree_size, (state_r == S_EMIT) && !res.disconnected,
                     $countones(in_tree_r) == int'(added_r),
                     "tree membership out of step with the edge count")

endmodule

`default_nettype wire

>>> rtl/core/prim_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// Prim spanning tree over a loaded weight matrix, with an output word register.
// ----------------------------------------------------------------------------
// Words on in_ch load a symmetric matrix of 16-bit weights (all ones = no
// edge) or start a run; each run emits one out_ch word per tree edge, the
// last one flagged, or ends early in a disconnected word, also flagged last.
// One command is worked at a time. An edge write is accepted and then written
// to both mirrored entries. A clear writes all 2^(2*ceil(log2(MAX_VERTICES)))
// matrix entries, and the same clearing pass runs after reset before the
// first word is taken. A run with n active vertices scans the n*(n-1)/2
// upper-triangle weights for its seed, one matrix read a cycle, then sweeps n
// nearest-vertex table entries per further edge, one entry a cycle, and
// hands each word to the output register; a stalled output holds the run.
`default_nettype none

module prim_minimum_spanning_tree import pmst_pkg::*; #(
  parameter int MAX_VERTICES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  pmst_in_if.sink                in_ch,
  pmst_out_if.source             out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  logic [VC_W-1:0] vertex_count;
  logic            res_valid;
  logic            res_take;
  res_t            res;
  logic            out_valid_r, out_valid_nxt;
  res_t            out_res_r, out_res_nxt;

  pmst_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .vertex_count (vertex_count)
  );

  pmst_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .vertex_count (vertex_count),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // output word register; loads when empty or being drained
  assign res_take = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    priority if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tree_vertex   = out_res_r.tree_vertex;
  assign out_ch.parent_vertex = out_res_r.parent_vertex;
  assign out_ch.edge_weight   = out_res_r.edge_weight;
  assign out_ch.last          = out_res_r.last;
  assign out_ch.disconnected  = out_res_r.disconnected;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Prim spanning tree block. Command words load the
// weight matrix and start runs; a built-in predictor grows the same tree and
// each out word is compared field by field. Vertex count is changed between
// phases over APB, both channels idle at random, and the result side holds
// off once for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import pmst_pkg::*;

  localparam int NV          = 16;
  localparam int SETTLE      = 300;     // covers a clear still in flight
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 330;
  localparam int NUM_PHASES  = 11;
  localparam int VC_PLAN [NUM_PHASES] = '{16, 2, 0, 31, 5, 12, 1, 17, 8, 3, 16};

  typedef struct packed {
    op_t  op;
    vtx_t row;
    vtx_t col;
    wgt_t w;
  } mst_cmd_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pmst_in_if  in_ch();
  pmst_out_if out_ch();

  prim_minimum_spanning_tree #(.MAX_VERTICES(NV)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  wgt_t            weights [NV][NV];
  logic [VC_W-1:0] vc_shadow = VC_RESET;
  vtx_t            nearest [NV];
  bit              joined  [NV];

  res_t     expected_edges [$];
  mst_cmd_t pending_cmds   [$];
  mst_cmd_t tx_cmd;
  res_t     want;

  int cmds_queued   = 0;
  int cmds_taken    = 0;
  int items_live    = 0;
  int runs_queued   = 0;
  int edges_checked = 0;
  int err_cnt       = 0;
  int cycle_cnt     = 0;
  int tx_gap        = 0;
  int rx_wait       = 0;
  int rx_draw       = 0;
  int hold_left     = 0;
  bit hold_used     = 1'b0;
  bit rx_open       = 1'b0;
  bit no_idle       = 1'b0;
  bit pressure_arm  = 1'b0;

  function automatic int active_vertices();
    int n;
    n = vc_shadow;
    if (n < 2) n = 2;
    if (n > NV) n = NV;
    return n;
  endfunction

  task automatic push_edge(input int tv, input int pv, input int w, input bit lst,
                           input bit disc);
    res_t e;
    e.tree_vertex   = vtx_t'(tv);
    e.parent_vertex = vtx_t'(pv);
    e.edge_weight   = wgt_t'(w);
    e.last          = lst;
    e.disconnected  = disc;
    expected_edges.push_back(e);
  endtask

  task automatic grow_tree();
    int  n, best, r, c, pick, added;
    bit  found;
    n     = active_vertices();
    best  = NO_EDGE;
    found = 1'b0;
    r     = 0;
    c     = 0;
    pick  = 0;
    for (int i = 0; i < NV; i++) joined[i] = 1'b0;
    // seed: cheapest edge, first strictly smaller in row order
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (weights[i][j] < best) begin
          best  = weights[i][j];
          r     = i;
          c     = j;
          found = 1'b1;
        end
    if (!found) begin
      push_edge(0, 0, NO_EDGE, 1'b1, 1'b1);
      return;
    end
    joined[r] = 1'b1;
    joined[c] = 1'b1;
    // tie keeps the row endpoint
    for (int k = 0; k < n; k++)
      nearest[k] = (weights[c][k] < weights[r][k]) ? vtx_t'(c) : vtx_t'(r);
    push_edge(c, r, best, n == 2, 1'b0);
    for (added = 2; added < n; added++) begin
      found = 1'b0;
      best  = NO_EDGE;
      for (int j = 0; j < n; j++)
        if (!joined[j] && weights[j][nearest[j]] < best) begin
          best  = weights[j][nearest[j]];
          pick  = j;
          found = 1'b1;
        end
      if (!found) begin
        push_edge(0, 0, NO_EDGE, 1'b1, 1'b1);
        return;
      end
      joined[pick] = 1'b1;
      push_edge(pick, nearest[pick], best, added + 1 == n, 1'b0);
      for (int k = 0; k < n; k++)
        if (!joined[k] && weights[pick][k] < weights[nearest[k]][k])
          nearest[k] = vtx_t'(pick);
    end
  endtask

  task automatic apply_cmd(input op_t op, input vtx_t row, input vtx_t col, input wgt_t w);
    case (op)
      OP_WRITE: begin
        weights[row][col] = w;
        weights[col][row] = w;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NV; i++)
          for (int j = 0; j < NV; j++) weights[i][j] = NO_EDGE;
      end
      OP_RUN: grow_tree();
      default: ;
    endcase
  endtask

  // ---------------- command side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_cmd(in_ch.operation, in_ch.row_vertex, in_ch.col_vertex, in_ch.weight);
        cmds_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap != 0) begin
          in_ch.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (pending_cmds.size() != 0) begin
          tx_cmd            = pending_cmds.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.operation  <= tx_cmd.op;
          in_ch.row_vertex <= tx_cmd.row;
          in_ch.col_vertex <= tx_cmd.col;
          in_ch.weight     <= tx_cmd.w;
          tx_gap           <= no_idle ? 0 : $urandom_range(0, 8);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result side
  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_open <= 1'b1;
      rx_wait <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (expected_edges.size() == 0) begin
        $error("unexpected result word: tree_vertex %0d parent_vertex %0d edge_weight %0d",
               out_ch.tree_vertex, out_ch.parent_vertex, out_ch.edge_weight);
        err_cnt++;
      end else begin
        want = expected_edges.pop_front();
        check_field("tree_vertex", want.tree_vertex, out_ch.tree_vertex);
        check_field("parent_vertex", want.parent_vertex, out_ch.parent_vertex);
        check_field("edge_weight", want.edge_weight, out_ch.edge_weight);
        check_field("last", want.last, out_ch.last);
        check_field("disconnected", want.disconnected, out_ch.disconnected);
        edges_checked++;
      end
      rx_draw = no_idle ? 0 : $urandom_range(0, 8);
      if (rx_draw != 0) begin
        rx_open <= 1'b0;
        rx_wait <= rx_draw;
      end
    end else if (!rx_open) begin
      if (rx_wait <= 1) begin
        rx_open <= 1'b1;
        rx_wait <= 0;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  // one long hold-off on the result side once armed
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (pressure_arm && !hold_used && out_ch.valid) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign out_ch.ready = rx_open && (hold_left == 0);

  // ---------------- stimulus helpers
  task automatic push_cmd(input op_t op, input int row, input int col, input int w);
    mst_cmd_t c;
    c.op  = op;
    c.row = vtx_t'(row);
    c.col = vtx_t'(col);
    c.w   = wgt_t'(w);
    pending_cmds.push_back(c);
    cmds_queued++;
    if (op != OP_NONE) items_live++;
    if (op == OP_RUN) runs_queued++;
  endtask

  task automatic push_write(input int a, input int b, input int w);
    if ($urandom_range(0, 1)) push_cmd(OP_WRITE, a, b, w);
    else push_cmd(OP_WRITE, b, a, w);
  endtask

  task automatic push_misc(input op_t op);
    push_cmd(op, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 65535));
  endtask

  function automatic int draw_weight(input int style);
    int pick;
    case (style)
      0: return $urandom_range(0, 3);    // lots of ties
      1: return $urandom_range(0, 65535);
      default: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return 0;
          1: return 16'hFFFE;
          2: return 16'hFFFF;
          3: return 16'h8000;
          4: return 16'h7FFF;
          default: return $urandom_range(0, 65535);
        endcase
      end
    endcase
  endfunction

  task automatic wait_idle();
    while (cmds_taken != cmds_queued || expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_VERTEX_COUNT, 2'b00};
    cfg_pwdata  <= ($urandom() & ~32'h1F) | (v & 32'h1F);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    vc_shadow = VC_W'(v);
  endtask

  // one graph ending in a run; mostly well-formed, some noise and broken ones
  task automatic push_graph_run();
    int n, kind, style, a, b, j, t;
    int order [NV];
    n     = active_vertices();
    kind  = $urandom_range(0, 9);
    style = $urandom_range(0, 2);
    if (kind != 9 && $urandom_range(0, 9) < 8) push_misc(OP_CLEAR);
    if (kind <= 4) begin
      // random path through every active vertex, then extra edges
      for (int i = 0; i < NV; i++) order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        t        = order[i];
        order[i] = order[j];
        order[j] = t;
      end
      for (int i = 1; i < n; i++) push_write(order[i-1], order[i], draw_weight(style));
      repeat ($urandom_range(0, n)) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        push_write(a, b, draw_weight(style));
      end
    end else if (kind <= 7) begin
      repeat ($urandom_range(1, 2 * n)) begin
        a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        push_write(a, b, draw_weight(style));
      end
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 3)) push_misc(OP_NONE);
      repeat ($urandom_range(1, 4)) begin
        a = (n < NV) ? $urandom_range(n, NV - 1) : $urandom_range(0, NV - 1);
        push_write(a, $urandom_range(0, 15), draw_weight(style));
      end
      push_misc(OP_WRITE);
    end else begin
      // no clear, a run in the middle of loading
      repeat ($urandom_range(1, n)) push_write($urandom_range(0, n - 1),
                                               $urandom_range(0, n - 1), draw_weight(style));
      push_misc(OP_RUN);
      repeat ($urandom_range(0, 3)) push_write($urandom_range(0, n - 1),
                                               $urandom_range(0, n - 1), 16'hFFFF);
    end
    push_misc(OP_RUN);
  endtask

  // ---------------- run control
  always @(posedge clk) cycle_cnt++;

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int start;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_NONE;
    in_ch.row_vertex = '0;
    in_ch.col_vertex = '0;
    in_ch.weight     = '0;
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++) weights[i][j] = NO_EDGE;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at the reset vertex count
    push_cmd(OP_RUN, 0, 0, 0);                 // empty matrix: disconnected word only
    push_cmd(OP_WRITE, 15, 0, 0);              // outside the active vertices
    push_cmd(OP_WRITE, 15, 15, 16'hFFFF);      // diagonal
    push_cmd(OP_WRITE, 3, 3, 0);               // diagonal, never used
    push_cmd(OP_WRITE, 0, 1, 16'hFFFE);
    push_cmd(OP_WRITE, 2, 3, 16'hFFFE);        // equal seed, first in row order wins
    push_cmd(OP_NONE, 15, 15, 16'hFFFF);
    push_cmd(OP_RUN, 15, 15, 16'hFFFF);        // seed, then unreachable
    push_cmd(OP_CLEAR, 0, 0, 0);
    push_cmd(OP_WRITE, 4, 5, 1);
    push_cmd(OP_WRITE, 4, 6, 7);
    push_cmd(OP_WRITE, 6, 5, 7);               // both seed ends equally near
    push_cmd(OP_WRITE, 6, 7, 3);
    push_cmd(OP_WRITE, 7, 0, 3);
    push_cmd(OP_WRITE, 0, 1, 3);
    push_cmd(OP_WRITE, 1, 2, 3);
    push_cmd(OP_WRITE, 2, 3, 9);
    push_cmd(OP_WRITE, 3, 7, 9);
    push_cmd(OP_RUN, 0, 0, 0);                 // full tree
    push_cmd(OP_WRITE, 5, 4, 16'hFFFF);        // drop the seed edge
    push_cmd(OP_RUN, 0, 0, 0);
    push_cmd(OP_WRITE, 7, 0, 0);
    push_cmd(OP_RUN, 0, 0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_vertex_count(VC_PLAN[p]);
      no_idle = (p % 4 == 3);
      if (p == 0) pressure_arm = 1'b1;
      start = items_live;
      while (items_live - start < RAND_ITEMS / NUM_PHASES) push_graph_run();
    end

    wait_idle();
    $display("covered %0d command words (%0d runs) over %0d vertex-count settings",
             items_live, runs_queued, NUM_PHASES + 1);
    $display("checked %0d tree-edge words, %0d mismatches", edges_checked, err_cnt);
    if (err_cnt == 0 && expected_edges.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
